@@ rtl/assert_macros.svh @@
// assertion macros for circle_circle_intersection
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while in reset
`define CCI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while in reset
`define CCI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cci_pkg.sv @@
// widths, types and helpers for the circle intersection pipeline
`default_nettype none
package cci_pkg;
    localparam int COORD_BITS = 15;
    localparam int FRAC_BITS  = 4;
    localparam int OUT_BITS   = COORD_BITS + 1 + FRAC_BITS;
    localparam int RAD_BITS   = COORD_BITS - 1;

    localparam int DIF_BITS  = COORD_BITS + 1;
    localparam int MAG_BITS  = COORD_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int RSQ_BITS  = 2 * RAD_BITS;
    localparam int D2_BITS   = SQ_BITS + 1;
    localparam int C_BITS    = D2_BITS + 2;
    localparam int AC_BITS   = D2_BITS + 1;
    localparam int AP_BITS   = RSQ_BITS + D2_BITS;
    localparam int A_BITS    = AP_BITS + 2;
    localparam int B_BITS    = 2 * AC_BITS;
    localparam int K_BITS    = A_BITS;
    localparam int KD_BITS   = ((A_BITS > B_BITS) ? A_BITS : B_BITS) + 1;
    localparam int SR_BITS   = (K_BITS + 2 * FRAC_BITS + 1) / 2;
    localparam int RADIC_BITS = 2 * SR_BITS;
    localparam int REM_BITS  = SR_BITS + 3;
    localparam int BXM_BITS  = MAG_BITS + AC_BITS;
    localparam int BX_BITS   = BXM_BITS + FRAC_BITS;
    localparam int TX_BITS   = MAG_BITS + SR_BITS;
    localparam int N_BITS    = ((BX_BITS > TX_BITS) ? BX_BITS : TX_BITS) + 2;
    localparam int N2_BITS   = N_BITS + 2;
    localparam int DEN_BITS  = D2_BITS + 2;
    localparam int M_BITS    = N2_BITS + 1;
    localparam int Q_BITS    = OUT_BITS + 2;
    localparam int QM_BITS   = Q_BITS + 1;
    localparam int V_BITS    = Q_BITS + 3;
    localparam int LANES     = 4;

    localparam int S_RAW_BITS  = 4 * COORD_BITS + 2 * RAD_BITS;
    localparam int S_DATA_BITS = 8 * ((S_RAW_BITS + 7) / 8);
    localparam int M_RAW_BITS  = 2 + 4 * OUT_BITS;
    localparam int M_DATA_BITS = 8 * ((M_RAW_BITS + 7) / 8);

    typedef enum logic [1:0] {
        CNT_NONE    = 2'd0,
        CNT_TANGENT = 2'd1,
        CNT_TWO     = 2'd2
    } cnt_t;

    // side data that rides along the square-root stages
    typedef struct packed {
        logic signed [BX_BITS:0]       bx;
        logic signed [BX_BITS:0]       by;
        logic [MAG_BITS-1:0]           adx;
        logic [MAG_BITS-1:0]           ady;
        logic                          ydneg;
        logic [D2_BITS-1:0]            d2;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        cnt_t                          cnt;
    } rt_pl_t;

    // side data that rides along the divide stages
    typedef struct packed {
        logic [DEN_BITS-1:0]           den;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        cnt_t                          cnt;
    } dv_pl_t;

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [V_BITS-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (!v[V_BITS-1] && (|v[V_BITS-2:OUT_BITS-1])) begin
            r = {1'b0, {(OUT_BITS-1){1'b1}}};
        end else if (v[V_BITS-1] && !(&v[V_BITS-2:OUT_BITS-1])) begin
            r = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            r = v[OUT_BITS-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/circle_circle_intersection.sv @@
// circle intersection pipeline, from s_ accept to m_tvalid
// throughput one item per cycle when not stalled; stalls back-pressure stage by stage and empty stages refill
// the pipeline has 35 square-root stages (one root bit each) and 22 divide stages
// (one quotient bit each) plus 13 arithmetic and output stages
// aresetn (synchronous, active low) clears every stage valid bit; data registers keep their value
`default_nettype none
`include "assert_macros.svh"
module circle_circle_intersection (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // center1_x, center1_y, radius1, center2_x, center2_y, radius2
    input  wire logic [cci_pkg::S_DATA_BITS-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // point_count, first_x, first_y, second_x, second_y, zero fill
    output logic [cci_pkg::M_DATA_BITS-1:0]       m_tdata
);
    import cci_pkg::*;

    localparam int P_IN   = 0;
    localparam int P_DIF  = 1;
    localparam int P_SQ   = 2;
    localparam int P_SUM  = 3;
    localparam int P_C    = 4;
    localparam int P_MUL  = 5;
    localparam int P_K    = 6;
    localparam int P_T    = P_K + SR_BITS + 1;
    localparam int P_N    = P_T + 1;
    localparam int P_N2   = P_T + 2;
    localparam int P_M    = P_T + 3;
    localparam int P_SAT  = P_T + 4;
    localparam int P_OUT  = P_SAT + Q_BITS + 1;
    localparam int NST    = P_OUT + 1;

    localparam int O_Y1 = COORD_BITS;
    localparam int O_R1 = 2 * COORD_BITS;
    localparam int O_X2 = 2 * COORD_BITS + RAD_BITS;
    localparam int O_Y2 = 3 * COORD_BITS + RAD_BITS;
    localparam int O_R2 = 4 * COORD_BITS + RAD_BITS;

    // handshake chain
    logic [NST-1:0] vld_reg, vld_next;
    logic [NST:0]   en;

    always_comb begin
        en[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        for (int i = 0; i < NST; i++) begin
            if (en[i]) begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];

    // input register
    logic signed [COORD_BITS-1:0] in_x1_reg, in_y1_reg, in_x2_reg, in_y2_reg;
    logic [RAD_BITS-1:0]          in_r1_reg, in_r2_reg;

    always_ff @(posedge aclk) begin
        if (en[P_IN]) begin
            in_x1_reg <= s_tdata[O_Y1-1:0];
            in_y1_reg <= s_tdata[O_R1-1:O_Y1];
            in_r1_reg <= s_tdata[O_X2-1:O_R1];
            in_x2_reg <= s_tdata[O_Y2-1:O_X2];
            in_y2_reg <= s_tdata[O_R2-1:O_Y2];
            in_r2_reg <= s_tdata[O_R2+RAD_BITS-1:O_R2];
        end
    end

    // centre differences
    logic signed [DIF_BITS-1:0]   dif_dx_reg, dif_dy_reg;
    logic [RAD_BITS-1:0]          dif_r1_reg, dif_r2_reg;
    logic signed [COORD_BITS-1:0] dif_x1_reg, dif_y1_reg;

    always_ff @(posedge aclk) begin
        if (en[P_DIF]) begin
            dif_dx_reg <= DIF_BITS'(in_x2_reg) - DIF_BITS'(in_x1_reg);
            dif_dy_reg <= DIF_BITS'(in_y2_reg) - DIF_BITS'(in_y1_reg);
            dif_r1_reg <= in_r1_reg;
            dif_r2_reg <= in_r2_reg;
            dif_x1_reg <= in_x1_reg;
            dif_y1_reg <= in_y1_reg;
        end
    end

    // magnitudes and squares
    logic [DIF_BITS-1:0]          adx_w, ady_w;
    logic [MAG_BITS-1:0]          sq_adx_reg, sq_ady_reg;
    logic                         sq_dxn_reg, sq_dyn_reg, sq_dyz_reg;
    logic [SQ_BITS-1:0]           sq_adx2_reg, sq_ady2_reg;
    logic [RSQ_BITS-1:0]          sq_r1s_reg, sq_r2s_reg;
    logic signed [COORD_BITS-1:0] sq_x1_reg, sq_y1_reg;

    assign adx_w = dif_dx_reg[DIF_BITS-1] ? DIF_BITS'(-dif_dx_reg) : DIF_BITS'(dif_dx_reg);
    assign ady_w = dif_dy_reg[DIF_BITS-1] ? DIF_BITS'(-dif_dy_reg) : DIF_BITS'(dif_dy_reg);

    always_ff @(posedge aclk) begin
        if (en[P_SQ]) begin
            sq_adx_reg  <= adx_w[MAG_BITS-1:0];
            sq_ady_reg  <= ady_w[MAG_BITS-1:0];
            sq_dxn_reg  <= dif_dx_reg[DIF_BITS-1];
            sq_dyn_reg  <= dif_dy_reg[DIF_BITS-1];
            sq_dyz_reg  <= (dif_dy_reg == '0);
            sq_adx2_reg <= SQ_BITS'(adx_w[MAG_BITS-1:0]) * SQ_BITS'(adx_w[MAG_BITS-1:0]);
            sq_ady2_reg <= SQ_BITS'(ady_w[MAG_BITS-1:0]) * SQ_BITS'(ady_w[MAG_BITS-1:0]);
            sq_r1s_reg  <= RSQ_BITS'(dif_r1_reg) * RSQ_BITS'(dif_r1_reg);
            sq_r2s_reg  <= RSQ_BITS'(dif_r2_reg) * RSQ_BITS'(dif_r2_reg);
            sq_x1_reg   <= dif_x1_reg;
            sq_y1_reg   <= dif_y1_reg;
        end
    end

    // d2 and difference of the squared radii
    logic [D2_BITS-1:0]           sum_d2_reg;
    logic signed [RSQ_BITS:0]     sum_e_reg;
    logic [RSQ_BITS-1:0]          sum_r1s_reg;
    logic [MAG_BITS-1:0]          sum_adx_reg, sum_ady_reg;
    logic                         sum_dxn_reg, sum_dyn_reg, sum_dyz_reg;
    logic signed [COORD_BITS-1:0] sum_x1_reg, sum_y1_reg;

    always_ff @(posedge aclk) begin
        if (en[P_SUM]) begin
            sum_d2_reg  <= D2_BITS'(sq_adx2_reg) + D2_BITS'(sq_ady2_reg);
            sum_e_reg   <= $signed((RSQ_BITS+1)'(sq_r1s_reg)) - $signed((RSQ_BITS+1)'(sq_r2s_reg));
            sum_r1s_reg <= sq_r1s_reg;
            sum_adx_reg <= sq_adx_reg;
            sum_ady_reg <= sq_ady_reg;
            sum_dxn_reg <= sq_dxn_reg;
            sum_dyn_reg <= sq_dyn_reg;
            sum_dyz_reg <= sq_dyz_reg;
            sum_x1_reg  <= sq_x1_reg;
            sum_y1_reg  <= sq_y1_reg;
        end
    end

    // c = d2 + r1^2 - r2^2
    logic signed [C_BITS-1:0]     c_w;
    logic [AC_BITS-1:0]           c_abs_reg;
    logic                         c_neg_reg;
    logic [D2_BITS-1:0]           c_d2_reg;
    logic [RSQ_BITS-1:0]          c_r1s_reg;
    logic [MAG_BITS-1:0]          c_adx_reg, c_ady_reg;
    logic                         c_dxn_reg, c_dyn_reg, c_dyz_reg;
    logic signed [COORD_BITS-1:0] c_x1_reg, c_y1_reg;

    assign c_w = $signed(C_BITS'(sum_d2_reg)) + C_BITS'(sum_e_reg);

    always_ff @(posedge aclk) begin
        if (en[P_C]) begin
            c_abs_reg <= c_w[C_BITS-1] ? AC_BITS'(-c_w) : AC_BITS'(c_w);
            c_neg_reg <= c_w[C_BITS-1];
            c_d2_reg  <= sum_d2_reg;
            c_r1s_reg <= sum_r1s_reg;
            c_adx_reg <= sum_adx_reg;
            c_ady_reg <= sum_ady_reg;
            c_dxn_reg <= sum_dxn_reg;
            c_dyn_reg <= sum_dyn_reg;
            c_dyz_reg <= sum_dyz_reg;
            c_x1_reg  <= sum_x1_reg;
            c_y1_reg  <= sum_y1_reg;
        end
    end

    // products
    logic [AP_BITS-1:0]           mul_a_reg;
    logic [B_BITS-1:0]            mul_b_reg;
    logic [BXM_BITS-1:0]          mul_bx_reg, mul_by_reg;
    logic                         mul_bxn_reg, mul_byn_reg, mul_ydneg_reg;
    logic [D2_BITS-1:0]           mul_d2_reg;
    logic [MAG_BITS-1:0]          mul_adx_reg, mul_ady_reg;
    logic signed [COORD_BITS-1:0] mul_x1_reg, mul_y1_reg;

    always_ff @(posedge aclk) begin
        if (en[P_MUL]) begin
            mul_a_reg     <= AP_BITS'(c_r1s_reg) * AP_BITS'(c_d2_reg);
            mul_b_reg     <= B_BITS'(c_abs_reg) * B_BITS'(c_abs_reg);
            mul_bx_reg    <= BXM_BITS'(c_adx_reg) * BXM_BITS'(c_abs_reg);
            mul_by_reg    <= BXM_BITS'(c_ady_reg) * BXM_BITS'(c_abs_reg);
            mul_bxn_reg   <= c_dxn_reg ^ c_neg_reg;
            mul_byn_reg   <= c_dyn_reg ^ c_neg_reg;
            // sign of the y offset term: dy sign, or dx sign when dy is zero, against dx sign
            mul_ydneg_reg <= (c_dyz_reg ? c_dxn_reg : c_dyn_reg) ^ c_dxn_reg;
            mul_d2_reg    <= c_d2_reg;
            mul_adx_reg   <= c_adx_reg;
            mul_ady_reg   <= c_ady_reg;
            mul_x1_reg    <= c_x1_reg;
            mul_y1_reg    <= c_y1_reg;
        end
    end

    // discriminant, feeds root stage 0
    logic signed [KD_BITS-1:0] k_w;
    logic signed [BX_BITS:0]   bx_pos_w, by_pos_w;
    rt_pl_t                    k_pl_w;

    assign k_w = $signed(KD_BITS'(mul_a_reg) << 2) - $signed(KD_BITS'(mul_b_reg));
    assign bx_pos_w = $signed((BX_BITS+1)'(mul_bx_reg) << FRAC_BITS);
    assign by_pos_w = $signed((BX_BITS+1)'(mul_by_reg) << FRAC_BITS);

    always_comb begin
        k_pl_w.bx    = mul_bxn_reg ? -bx_pos_w : bx_pos_w;
        k_pl_w.by    = mul_byn_reg ? -by_pos_w : by_pos_w;
        k_pl_w.adx   = mul_adx_reg;
        k_pl_w.ady   = mul_ady_reg;
        k_pl_w.ydneg = mul_ydneg_reg;
        k_pl_w.d2    = mul_d2_reg;
        k_pl_w.x1    = mul_x1_reg;
        k_pl_w.y1    = mul_y1_reg;
        if (mul_d2_reg == '0 || k_w[KD_BITS-1]) begin
            k_pl_w.cnt = CNT_NONE;
        end else if (k_w == '0) begin
            k_pl_w.cnt = CNT_TANGENT;
        end else begin
            k_pl_w.cnt = CNT_TWO;
        end
    end

    // square root, one result bit per stage
    logic [REM_BITS-1:0]   rt_rem_reg  [SR_BITS+1];
    logic [SR_BITS-1:0]    rt_root_reg [SR_BITS+1];
    logic [RADIC_BITS-1:0] rt_rad_reg  [SR_BITS+1];
    rt_pl_t                rt_pl_reg   [SR_BITS+1];

    always_ff @(posedge aclk) begin
        if (en[P_K]) begin
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_rad_reg[0]  <= k_w[KD_BITS-1] ? '0
                            : (RADIC_BITS'(k_w[K_BITS-1:0]) << (2 * FRAC_BITS));
            rt_pl_reg[0]   <= k_pl_w;
        end
    end

    for (genvar j = 0; j < SR_BITS; j++) begin : g_root
        logic [REM_BITS-1:0] t_w, trial_w;
        assign t_w     = {rt_rem_reg[j][REM_BITS-3:0], rt_rad_reg[j][RADIC_BITS-1 -: 2]};
        assign trial_w = REM_BITS'({rt_root_reg[j], 2'b01});

        always_ff @(posedge aclk) begin
            if (en[P_K+1+j]) begin
                if (t_w >= trial_w) begin
                    rt_rem_reg[j+1]  <= t_w - trial_w;
                    rt_root_reg[j+1] <= {rt_root_reg[j][SR_BITS-2:0], 1'b1};
                end else begin
                    rt_rem_reg[j+1]  <= t_w;
                    rt_root_reg[j+1] <= {rt_root_reg[j][SR_BITS-2:0], 1'b0};
                end
                rt_rad_reg[j+1] <= rt_rad_reg[j] << 2;
                rt_pl_reg[j+1]  <= rt_pl_reg[j];
            end
        end
    end

    // root times the offsets
    logic [TX_BITS-1:0] t_txm_reg, t_tym_reg;
    rt_pl_t             t_pl_reg;

    always_ff @(posedge aclk) begin
        if (en[P_T]) begin
            t_txm_reg <= TX_BITS'(rt_pl_reg[SR_BITS].ady) * TX_BITS'(rt_root_reg[SR_BITS]);
            t_tym_reg <= TX_BITS'(rt_pl_reg[SR_BITS].adx) * TX_BITS'(rt_root_reg[SR_BITS]);
            t_pl_reg  <= rt_pl_reg[SR_BITS];
        end
    end

    // numerators: first x, first y, second x, second y
    logic signed [N_BITS-1:0] tx_w, ty_w, bx_w, by_w;
    logic signed [N_BITS-1:0] n_reg [LANES];
    dv_pl_t                   n_pl_reg;

    assign tx_w = $signed(N_BITS'(t_txm_reg));
    assign ty_w = t_pl_reg.ydneg ? -$signed(N_BITS'(t_tym_reg)) : $signed(N_BITS'(t_tym_reg));
    assign bx_w = N_BITS'(t_pl_reg.bx);
    assign by_w = N_BITS'(t_pl_reg.by);

    always_ff @(posedge aclk) begin
        if (en[P_N]) begin
            n_reg[0]     <= bx_w - tx_w;
            n_reg[1]     <= by_w + ty_w;
            n_reg[2]     <= bx_w + tx_w;
            n_reg[3]     <= by_w - ty_w;
            n_pl_reg.den <= DEN_BITS'(t_pl_reg.d2) << 2;
            n_pl_reg.x1  <= t_pl_reg.x1;
            n_pl_reg.y1  <= t_pl_reg.y1;
            n_pl_reg.cnt <= t_pl_reg.cnt;
        end
    end

    // round half up: 2n + 2*d2 over 4*d2
    logic signed [N2_BITS-1:0] n2_reg [LANES];
    dv_pl_t                    n2_pl_reg;

    always_ff @(posedge aclk) begin
        if (en[P_N2]) begin
            for (int i = 0; i < LANES; i++) begin
                n2_reg[i] <= (N2_BITS'(n_reg[i]) <<< 1) + $signed(N2_BITS'(n_pl_reg.den >> 1));
            end
            n2_pl_reg <= n_pl_reg;
        end
    end

    // magnitude for floor division of a negative numerator
    logic [M_BITS-1:0] m_reg   [LANES];
    logic              m_neg_reg [LANES];
    dv_pl_t            m_pl_reg;

    always_ff @(posedge aclk) begin
        if (en[P_M]) begin
            for (int i = 0; i < LANES; i++) begin
                m_neg_reg[i] <= n2_reg[i][N2_BITS-1];
                m_reg[i]     <= n2_reg[i][N2_BITS-1]
                              ? M_BITS'($unsigned(~n2_reg[i])) + M_BITS'(n2_pl_reg.den)
                              : M_BITS'($unsigned(n2_reg[i]));
            end
            m_pl_reg <= n2_pl_reg;
        end
    end

    // quotients too large for the output saturate anyway
    logic [M_BITS-1:0]  dv_rem_reg [Q_BITS+1][LANES];
    logic [Q_BITS-1:0]  dv_q_reg   [Q_BITS+1][LANES];
    logic               dv_neg_reg [Q_BITS+1][LANES];
    logic               dv_sat_reg [Q_BITS+1][LANES];
    dv_pl_t             dv_pl_reg  [Q_BITS+1];

    always_ff @(posedge aclk) begin
        if (en[P_SAT]) begin
            for (int i = 0; i < LANES; i++) begin
                dv_rem_reg[0][i] <= m_reg[i];
                dv_q_reg[0][i]   <= '0;
                dv_neg_reg[0][i] <= m_neg_reg[i];
                dv_sat_reg[0][i] <= m_reg[i] >= (M_BITS'(m_pl_reg.den) << Q_BITS);
            end
            dv_pl_reg[0] <= m_pl_reg;
        end
    end

    for (genvar d = 0; d < Q_BITS; d++) begin : g_div
        logic [M_BITS-1:0] sub_w;
        assign sub_w = M_BITS'(dv_pl_reg[d].den) << (Q_BITS - 1 - d);

        always_ff @(posedge aclk) begin
            if (en[P_SAT+1+d]) begin
                for (int i = 0; i < LANES; i++) begin
                    if (dv_rem_reg[d][i] >= sub_w) begin
                        dv_rem_reg[d+1][i] <= dv_rem_reg[d][i] - sub_w;
                        dv_q_reg[d+1][i]   <= {dv_q_reg[d][i][Q_BITS-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[d+1][i] <= dv_rem_reg[d][i];
                        dv_q_reg[d+1][i]   <= {dv_q_reg[d][i][Q_BITS-2:0], 1'b0};
                    end
                    dv_neg_reg[d+1][i] <= dv_neg_reg[d][i];
                    dv_sat_reg[d+1][i] <= dv_sat_reg[d][i];
                end
                dv_pl_reg[d+1] <= dv_pl_reg[d];
            end
        end
    end

    // add the centre, saturate (zero when there is no intersection), output register
    logic signed [OUT_BITS-1:0] res_w [LANES];
    cnt_t                       out_cnt_reg;
    logic signed [OUT_BITS-1:0] out_fx_reg, out_fy_reg, out_sx_reg, out_sy_reg;

    always_comb begin
        logic [QM_BITS-1:0]          qm;
        logic signed [QM_BITS:0]     qs;
        logic signed [COORD_BITS-1:0] ctr;
        for (int i = 0; i < LANES; i++) begin
            qm  = dv_sat_reg[Q_BITS][i] ? (QM_BITS'(1) << Q_BITS) : QM_BITS'(dv_q_reg[Q_BITS][i]);
            qs  = dv_neg_reg[Q_BITS][i] ? -$signed((QM_BITS+1)'(qm)) : $signed((QM_BITS+1)'(qm));
            ctr = (i % 2 == 0) ? dv_pl_reg[Q_BITS].x1 : dv_pl_reg[Q_BITS].y1;
            if (dv_pl_reg[Q_BITS].cnt == CNT_NONE) begin
                res_w[i] = '0;
            end else begin
                res_w[i] = sat_out(V_BITS'(qs) + (V_BITS'(ctr) <<< FRAC_BITS));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[P_OUT]) begin
            out_cnt_reg <= dv_pl_reg[Q_BITS].cnt;
            out_fx_reg  <= res_w[0];
            out_fy_reg  <= res_w[1];
            out_sx_reg  <= res_w[2];
            out_sy_reg  <= res_w[3];
        end
    end

    assign m_tdata = M_DATA_BITS'({out_sy_reg, out_sx_reg, out_fy_reg, out_fx_reg, out_cnt_reg});

    `CCI_ASSERT_IMP(a_none_zero, aclk, aresetn, m_tvalid && out_cnt_reg == CNT_NONE, out_fx_reg == '0 && out_fy_reg == '0 && out_sx_reg == '0 && out_sy_reg == '0)
    `CCI_ASSERT_IMP(a_tangent_same, aclk, aresetn, m_tvalid && out_cnt_reg == CNT_TANGENT, out_sx_reg == out_fx_reg && out_sy_reg == out_fy_reg)
    `CCI_ASSERT_IMP(a_stall_only, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `CCI_ASSERT_NXT(a_drain, aclk, aresetn, vld_reg[P_OUT-1] && en[P_OUT], m_tvalid)
endmodule
`default_nettype wire
